FILE: rtl/rso_pkg.sv
// Shared package for the range sensor odometer: widths, register indexes,
// pipeline stage types and the cosine table builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rso_pkg;

    // Fixed field widths
    localparam int MM_W       = 16;             // wall distance, cell size, fallback
    localparam int HEAD_W     = 14;             // heading, 1/16 degree
    localparam int DELTA_W    = MM_W + 1;       // signed motion
    localparam int TOTAL_W    = 32;             // running distance
    localparam int CELL_W     = MM_W + 1;       // cell size, zero read as 65536

    // Cosine scaling
    localparam int COS_FRAC_BITS = 15;
    localparam int COS_W      = COS_FRAC_BITS + 1;   // magnitude, up to 1.0
    localparam int SCOS_W     = COS_W + 1;           // signed cosine
    localparam int PROD_W     = SCOS_W + DELTA_W;
    localparam int P_W        = PROD_W + 1;

    // Angle folding, sixteenths of a degree
    localparam int TURN       = 5760;
    localparam int HALF_TURN  = 2880;
    localparam int QUARTER    = 1440;
    localparam int ANGLE_W    = 16;             // offset difference stays below 2^16
    localparam int ANGLE_OFFSET = 3 * TURN;     // lifts any 14-bit difference above zero
    localparam int T_W        = $clog2(QUARTER + 1);

    // Cell position remainder: bits consumed per pipeline stage
    localparam int REM_BITS_PER_STAGE = 4;

    // Stream and configuration ports
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MM_W;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = CFG_IDX_W'(1);

    localparam logic [MM_W-1:0] CELL_SIZE_RESET = MM_W'(400);
    localparam logic [MM_W-1:0] FALLBACK_RESET  = MM_W'(200);

    // Table construction constants (Q30)
    localparam longint Q30_ONE = 64'd1 << 30;
    localparam longint PI_Q30  = 64'd3373259426;
    localparam longint TAYLOR_DIV [6] = '{132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic                     mode;
        logic [MM_W-1:0]          front;
        logic [MM_W-1:0]          back;
        logic                     front_ok;
        logic                     back_ok;
        logic signed [HEAD_W-1:0] heading;
        logic signed [HEAD_W-1:0] ref_heading;
    } in_item_t;

    typedef struct packed {
        logic [T_W-1:0]            angle;    // first-quadrant angle
        logic                      cos_neg;
        logic signed [DELTA_W-1:0] delta;
        logic                      still;
    } motion_t;

    typedef struct packed {
        logic [MM_W-1:0] rem;       // partial remainder
        logic [MM_W-1:0] operand;   // reading being reduced
        logic            use_rem;   // back <= front: position is the remainder
        logic            failed;
    } cellpos_t;

    typedef struct packed {
        logic                      cos_neg;
        logic signed [DELTA_W-1:0] delta;
        logic                      still;
        logic                      mode;
        cellpos_t                  cp;
    } s2_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     still;
        logic                     mode;
        cellpos_t                 cp;
    } s3_t;

    typedef struct packed {
        logic [MM_W-1:0] distance;
        logic            still;
        cellpos_t        cp;
    } s4_t;

    typedef logic [COS_W-1:0] cos_rom_t [0:QUARTER];

    // cos(t/16 deg) for t in [0, QUARTER]: nested Taylor form to x^12 in Q30,
    // floored at each step, then rounded half up to Q(COS_FRAC_BITS).
    function automatic cos_rom_t cos_rom_build();
        cos_rom_t rom;
        longint   x;
        longint   x2;
        longint   r;
        longint   c;
        int       t;
        int       i;
        for (t = 0; t <= QUARTER; t++) begin
            x  = (longint'(t) * PI_Q30) / HALF_TURN;
            x2 = (x * x) >>> 30;
            r  = Q30_ONE;
            for (i = 0; i < 6; i++) begin
                if (r < 0) r = 0;
                r = Q30_ONE - ((x2 * r) >>> 30) / TAYLOR_DIV[i];
            end
            if (r < 0) r = 0;
            if (r > Q30_ONE) r = Q30_ONE;
            c = (r + (64'd1 << (29 - COS_FRAC_BITS))) >>> (30 - COS_FRAC_BITS);
            rom[t] = COS_W'(c);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rso_cos_rom.sv
// Quarter-wave cosine ROM with registered read.
// Depends on rso_pkg (table builder, widths).
`timescale 1ns / 1ps
`default_nettype none

module rso_cos_rom
    import rso_pkg::*;
(
    input  wire              aclk,
    input  wire              en,
    input  wire [T_W-1:0]    addr,
    output logic [COS_W-1:0] data
);

    localparam cos_rom_t COS_ROM = cos_rom_build();

    always_ff @(posedge aclk) begin
        if (en) begin
            data <= COS_ROM[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rso_rem_stage.sv
// One slice of the restoring remainder used for the cell position.
// Depends on rso_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none

module rso_rem_stage
    import rso_pkg::*;
(
    input  wire [MM_W-1:0]               rem_in,
    input  wire [REM_BITS_PER_STAGE-1:0] bits_in,
    input  wire [CELL_W-1:0]             cell_span,
    output logic [MM_W-1:0]              rem_out
);

    // rem < cell_span <= 65536 holds before and after every step
    always_comb begin
        logic [CELL_W-1:0] trial;
        rem_out = rem_in;
        for (int k = REM_BITS_PER_STAGE - 1; k >= 0; k--) begin
            trial = {rem_out, bits_in[k]};
            if (trial >= cell_span) begin
                trial = trial - cell_span;
            end
            rem_out = trial[MM_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rso_motion.sv
// Motion front end: previous readings, per-sensor motion, wall selection
// and heading difference folded into the first quadrant.
// Depends on rso_pkg (types, angle constants).
`timescale 1ns / 1ps
`default_nettype none

module rso_motion
    import rso_pkg::*;
(
    input  wire           aclk,
    input  wire           aresetn,
    input  wire in_item_t item,
    input  wire           shift,     // item leaves this stage
    output motion_t       motion
);

    localparam logic [ANGLE_W-1:0] TURN4 = ANGLE_W'(4 * TURN);
    localparam logic [ANGLE_W-1:0] TURN2 = ANGLE_W'(2 * TURN);
    localparam logic [ANGLE_W-1:0] TURN1 = ANGLE_W'(TURN);
    localparam logic [ANGLE_W-1:0] HALF1 = ANGLE_W'(HALF_TURN);
    localparam logic [ANGLE_W-1:0] QTR1  = ANGLE_W'(QUARTER);
    localparam logic [ANGLE_W-1:0] QTR3  = ANGLE_W'(HALF_TURN + QUARTER);

    logic [MM_W-1:0] prev_front_reg;
    logic [MM_W-1:0] prev_back_reg;
    logic            prev_front_ok_reg;
    logic            prev_back_ok_reg;

    logic signed [DELTA_W-1:0] front_move;
    logic signed [DELTA_W-1:0] back_move;
    logic signed [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W-1:0]        a0;
    logic [ANGLE_W-1:0]        a1;
    logic [ANGLE_W-1:0]        a2;
    logic [ANGLE_W-1:0]        a3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_front_reg    <= '0;
            prev_back_reg     <= '0;
            prev_front_ok_reg <= 1'b0;
            prev_back_ok_reg  <= 1'b0;
        end else if (shift) begin
            prev_front_reg    <= item.front;
            prev_back_reg     <= item.back;
            prev_front_ok_reg <= item.front_ok;
            prev_back_ok_reg  <= item.back_ok;
        end
    end

    always_comb begin
        // Wall motion
        front_move = '0;
        back_move  = '0;
        if (prev_front_ok_reg && item.front_ok) begin
            front_move = signed'({1'b0, prev_front_reg}) - signed'({1'b0, item.front});
        end
        if (prev_back_ok_reg && item.back_ok) begin
            back_move = signed'({1'b0, item.back}) - signed'({1'b0, prev_back_reg});
        end
        motion.still = (front_move == '0) && (back_move == '0);
        if ((front_move != '0) && (back_move != '0)) begin
            // both walls moved: trust the nearer one
            motion.delta = (item.front < item.back) ? front_move : back_move;
        end else begin
            motion.delta = front_move + back_move;
        end

        // Heading difference modulo one turn, then quadrant fold
        angle_sum = (ANGLE_W + 1)'(item.heading) - (ANGLE_W + 1)'(item.ref_heading)
                  + (ANGLE_W + 1)'(ANGLE_OFFSET);
        a0 = angle_sum[ANGLE_W-1:0];
        a1 = (a0 >= TURN4) ? a0 - TURN4 : a0;
        a2 = (a1 >= TURN2) ? a1 - TURN2 : a1;
        a3 = (a2 >= TURN1) ? a2 - TURN1 : a2;
        if (a3 <= QTR1) begin
            motion.angle   = T_W'(a3);
            motion.cos_neg = 1'b0;
        end else if (a3 < HALF1) begin
            motion.angle   = T_W'(HALF1 - a3);
            motion.cos_neg = 1'b1;
        end else if (a3 <= QTR3) begin
            motion.angle   = T_W'(a3 - HALF1);
            motion.cos_neg = 1'b1;
        end else begin
            motion.angle   = T_W'(TURN1 - a3);
            motion.cos_neg = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rso_accum.sv
// Adds half an LSB to the scaled motion, shifts it toward zero and keeps the running distance.
// Depends on rso_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none

module rso_accum
    import rso_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     update,    // item leaves this stage
    input  wire signed [PROD_W-1:0] product,
    input  wire                     still,
    input  wire                     mode,      // clear after update
    output logic [MM_W-1:0]         distance
);

    localparam logic signed [P_W-1:0] HALF_LSB = P_W'(2 ** (COS_FRAC_BITS - 1));
    localparam logic signed [P_W-1:0] CEIL_ADJ = P_W'(2 ** COS_FRAC_BITS - 1);

    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic signed [P_W-1:0] rounded;
    logic signed [P_W-1:0] scaled;
    logic [TOTAL_W-1:0]    increment;

    always_comb begin
        rounded = P_W'(product) + HALF_LSB;
        // shift toward zero: negative values round up
        if (rounded[P_W-1]) begin
            scaled = (rounded + CEIL_ADJ) >>> COS_FRAC_BITS;
        end else begin
            scaled = rounded >>> COS_FRAC_BITS;
        end
        increment  = TOTAL_W'(scaled);
        total_next = still ? total_reg : total_reg + increment;
        if (mode) begin
            total_next = '0;
        end
        distance = total_next[MM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (update) begin
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/range_sensor_odometer_top.sv
// Top level of the range sensor odometer: stream ports, configuration
// registers and the four-stage pipeline. Depends on rso_pkg, rso_motion,
// rso_cos_rom, rso_rem_stage and rso_accum.
`timescale 1ns / 1ps
`default_nettype none

// Wall-range odometer. Each request carries one front/back distance pair,
// their valid flags, the current heading and the reference heading; each
// request produces exactly one result with the running distance (low 16
// bits, wrapping), a no-motion flag, and the position within the current
// maze cell (or fallback_mm when both readings are invalid). A new request
// can be taken every cycle unless m_tready back-pressure has filled the
// pipeline; a result passes through the stage 1 to 4 and output registers
// to m_tdata, and the stages keep filling while a result waits on m_tready.
// The cell position remainder is reduced four bits per stage, and the
// registered cosine ROM read and the multiply share those stages. Mode 1
// updates the stored readings and then clears the distance, so that result
// reads zero. Configuration (cfg_index 0 = cell_size_mm, 1 = fallback_mm)
// is always ready and must only be written while no request is in flight;
// a cell size of zero acts as 65536. No clearing pass is needed after reset.

module range_sensor_odometer_top
    import rso_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,

    // s_tdata: front_mm[15:0], back_mm[31:16], front_ok[32], back_ok[33],
    //          heading[47:34], ref_heading[61:48], zero[63:62]
    input  wire [IN_DATA_W-1:0]   s_tdata,
    // s_tuser: mode[0]
    input  wire                   s_tuser,
    input  wire                   s_tvalid,
    output logic                  s_tready,

    // m_tdata: distance_mm[15:0], no_motion[16], cell_pos_mm[32:17],
    //          cell_pos_failed[33], zero[39:34]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  wire                   m_tready,

    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [MM_W-1:0]   cell_size_reg;
    logic [MM_W-1:0]   fallback_reg;
    logic [CELL_W-1:0] cell_span;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= CELL_SIZE_RESET;
            fallback_reg  <= FALLBACK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CELL_SIZE: cell_size_reg <= cfg_data;
                REG_FALLBACK:  fallback_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero cell size means a full 16-bit span
    assign cell_span = (cell_size_reg == '0) ? {1'b1, {MM_W{1'b0}}} : {1'b0, cell_size_reg};

    // ---------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its contents
    // move on in the same cycle.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg      <= s_tvalid;
            if (rdy2)    v2_reg      <= v1_reg;
            if (rdy3)    v3_reg      <= v2_reg;
            if (rdy4)    v4_reg      <= v3_reg;
            if (rdy_out) m_valid_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    in_item_t s1_reg;
    in_item_t s1_next;

    always_comb begin
        s1_next.mode        = s_tuser;
        s1_next.front       = s_tdata[15:0];
        s1_next.back        = s_tdata[31:16];
        s1_next.front_ok    = s_tdata[32];
        s1_next.back_ok     = s_tdata[33];
        s1_next.heading     = s_tdata[47:34];
        s1_next.ref_heading = s_tdata[61:48];
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
    end

    // motion, wall choice and folded angle; previous readings advance as
    // the request leaves stage 1
    motion_t motion;

    rso_motion u_motion (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (s1_reg),
        .shift   (v1_reg && rdy2),
        .motion  (motion)
    );

    // cell position operand and top remainder bits
    cellpos_t cp1;
    logic [MM_W-1:0] rem1;
    logic [MM_W-1:0] operand1;

    assign operand1 = (s1_reg.back <= s1_reg.front) ? s1_reg.back : s1_reg.front;

    always_comb begin
        cp1.use_rem = (s1_reg.back <= s1_reg.front);
        cp1.operand = operand1;
        cp1.failed  = !s1_reg.front_ok && !s1_reg.back_ok;
        cp1.rem     = rem1;
    end

    rso_rem_stage u_rem1 (
        .rem_in    ('0),
        .bits_in   (operand1[MM_W-1 -: REM_BITS_PER_STAGE]),
        .cell_span (cell_span),
        .rem_out   (rem1)
    );

    // ---------------------------------------------------------------
    // Stage 2: cosine ROM output alongside the motion
    // ---------------------------------------------------------------
    s2_t s2_reg;
    s2_t s2_next;
    logic [COS_W-1:0] cos_mag;

    rso_cos_rom u_cos_rom (
        .aclk (aclk),
        .en   (rdy2),
        .addr (motion.angle),
        .data (cos_mag)
    );

    always_comb begin
        s2_next.cos_neg = motion.cos_neg;
        s2_next.delta   = motion.delta;
        s2_next.still   = motion.still;
        s2_next.mode    = s1_reg.mode;
        s2_next.cp      = cp1;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_reg <= s2_next;
        end
    end

    logic signed [SCOS_W-1:0] cos_signed;
    logic [MM_W-1:0] rem2;
    s3_t s3_next;
    s3_t s3_reg;

    rso_rem_stage u_rem2 (
        .rem_in    (s2_reg.cp.rem),
        .bits_in   (s2_reg.cp.operand[MM_W-1-REM_BITS_PER_STAGE -: REM_BITS_PER_STAGE]),
        .cell_span (cell_span),
        .rem_out   (rem2)
    );

    always_comb begin
        cos_signed = s2_reg.cos_neg ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});
        s3_next.product = PROD_W'(cos_signed) * PROD_W'(s2_reg.delta);
        s3_next.still   = s2_reg.still;
        s3_next.mode    = s2_reg.mode;
        s3_next.cp      = s2_reg.cp;
        s3_next.cp.rem  = rem2;
    end

    // ---------------------------------------------------------------
    // Stage 3: product; total advances as the request leaves
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_reg <= s3_next;
        end
    end

    logic [MM_W-1:0] distance3;
    logic [MM_W-1:0] rem3;
    s4_t s4_next;
    s4_t s4_reg;

    rso_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (v3_reg && rdy4),
        .product  (s3_reg.product),
        .still    (s3_reg.still),
        .mode     (s3_reg.mode),
        .distance (distance3)
    );

    rso_rem_stage u_rem3 (
        .rem_in    (s3_reg.cp.rem),
        .bits_in   (s3_reg.cp.operand[MM_W-1-2*REM_BITS_PER_STAGE -: REM_BITS_PER_STAGE]),
        .cell_span (cell_span),
        .rem_out   (rem3)
    );

    always_comb begin
        s4_next.distance = distance3;
        s4_next.still    = s3_reg.still;
        s4_next.cp       = s3_reg.cp;
        s4_next.cp.rem   = rem3;
    end

    // ---------------------------------------------------------------
    // Stage 4: last remainder bits and the cell position
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_reg <= s4_next;
        end
    end

    logic [MM_W-1:0]   rem4;
    logic [CELL_W-1:0] pos_wide;
    logic [MM_W-1:0]   cell_pos;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    rso_rem_stage u_rem4 (
        .rem_in    (s4_reg.cp.rem),
        .bits_in   (s4_reg.cp.operand[MM_W-1-3*REM_BITS_PER_STAGE -: REM_BITS_PER_STAGE]),
        .cell_span (cell_span),
        .rem_out   (rem4)
    );

    always_comb begin
        pos_wide = s4_reg.cp.use_rem ? {1'b0, rem4} : cell_span - {1'b0, rem4};
        cell_pos = s4_reg.cp.failed ? fallback_reg : pos_wide[MM_W-1:0];
        m_tdata_next = {6'd0, s4_reg.cp.failed, cell_pos, s4_reg.still, s4_reg.distance};
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire
